FILE: sv/dcfm_pkg.sv
// ----------------------------------------------------------------------------
// Drive command filter package
// Shared status codes, register reset value and mixing gains.
// ----------------------------------------------------------------------------
package dcfm_pkg;

  // Status code returned with every packet.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHECK = 2'd1,
    ST_STALE     = 2'd2,
    ST_RESYNC    = 2'd3
  } status_t;

  // Reset value of the rollover gap register.
  localparam logic [15:0] GAP_RESET = 16'd50000;

  // Mixing gains, held as 10-bit signed constants.
  localparam logic signed [9:0] LEFT_GAIN  = 10'sd323;
  localparam logic signed [9:0] RIGHT_GAIN = 10'sd85;

endpackage

FILE: sv/dcfm_if.sv
// ----------------------------------------------------------------------------
// Drive command filter channels
// Command packet channel and drive result channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// Incoming joystick command packet.
interface dcfm_cmd_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] stick_x;
  logic signed [7:0] stick_y;
  logic [15:0]       sequence_number;
  logic [7:0]        check_byte;

  modport source (output valid, stick_x, stick_y, sequence_number, check_byte,
                  input ready);
  modport sink   (input valid, stick_x, stick_y, sequence_number, check_byte,
                  output ready);
endinterface

// Outgoing drive result.
interface dcfm_drv_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;

  modport source (output valid, status, left_drive, right_drive, input ready);
  modport sink   (input valid, status, left_drive, right_drive, output ready);
endinterface

FILE: sv/dcfm_mixer.sv
// ----------------------------------------------------------------------------
// Drive mixer
// Mixes stick x and y into left and right drive values.
// ----------------------------------------------------------------------------
module dcfm_mixer
  import dcfm_pkg::*;
(
  input  logic signed [7:0]  stick_x,
  input  logic signed [7:0]  stick_y,
  output logic signed [15:0] left_drive,
  output logic signed [15:0] right_drive
);

  logic signed [9:0]  sum_neg;
  logic signed [9:0]  dif_neg;
  logic signed [19:0] left_prod;
  logic signed [19:0] left_bias;
  logic signed [19:0] right_prod;

  // Negated sum and difference, wide enough to hold +256.
  always_comb begin
    sum_neg = -({{2{stick_x[7]}}, stick_x} + {{2{stick_y[7]}}, stick_y});
    dif_neg = -({{2{stick_x[7]}}, stick_x} - {{2{stick_y[7]}}, stick_y});
  end

  // Left: scale by 323, then divide by 4 rounding toward zero.
  always_comb begin
    left_prod  = sum_neg * LEFT_GAIN;
    left_bias  = left_prod + (left_prod[19] ? 20'sd3 : 20'sd0);
    left_drive = 16'(left_bias >>> 2);
  end

  // Right: scale by 85; the result always fits 16 bits.
  always_comb begin
    right_prod  = dif_neg * RIGHT_GAIN;
    right_drive = right_prod[15:0];
  end

endmodule

FILE: sv/dcfm_seq_filter.sv
// ----------------------------------------------------------------------------
// Sequence filter
// Checks the packet check byte and sequence number, holds the last sequence
// number and the rollover gap register.
// ----------------------------------------------------------------------------
module dcfm_seq_filter
  import dcfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  input  logic        step,
  input  logic [7:0]  stick_x,
  input  logic [7:0]  stick_y,
  input  logic [15:0] sequence_number,
  input  logic [7:0]  check_byte,
  output status_t     status
);

  logic [15:0]        rollover_gap;
  logic [15:0]        last_sequence;
  logic [15:0]        last_sequence_next;
  logic signed [16:0] seq_diff;
  logic               check_ok;
  logic               resync;
  logic               newer;

  // Packet checks against the stored number.
  always_comb begin
    check_ok = ((stick_x ^ stick_y) == check_byte);
    seq_diff = $signed({1'b0, last_sequence}) - $signed({1'b0, sequence_number});
    resync   = (seq_diff > $signed({1'b0, rollover_gap}));
    newer    = (sequence_number > last_sequence);
  end

  // Status and next stored number. A resync makes the newer test fail.
  always_comb begin
    last_sequence_next = last_sequence;
    if (!check_ok) begin
      status = ST_BAD_CHECK;
    end else if (resync) begin
      status             = ST_RESYNC;
      last_sequence_next = sequence_number;
    end else if (newer) begin
      status             = ST_OK;
      last_sequence_next = sequence_number;
    end else begin
      status = ST_STALE;
    end
  end

  // Stored sequence number, updated once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence <= '0;
    end else if (step) begin
      last_sequence <= last_sequence_next;
    end
  end

  // Rollover gap register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_gap <= GAP_RESET;
    end else if (wr_en) begin
      rollover_gap <= wr_data;
    end
  end

endmodule

FILE: sv/drive_command_filter_mixer.sv
// ----------------------------------------------------------------------------
// Drive command filter and mixer
// Each command transaction passes the input and result registers.
// Throughput: one command per cycle while drv.ready holds; one result each.
// The stored sequence number is read and written in the same cycle.
// Reset: synchronous; clears the last sequence number to zero, sets the
// rollover gap to 50000 and empties both pipeline registers.
// ----------------------------------------------------------------------------
module drive_command_filter_mixer
  import dcfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  dcfm_cmd_if.sink    cmd,
  dcfm_drv_if.source  drv
);

  logic               in_valid;
  logic signed [7:0]  in_x;
  logic signed [7:0]  in_y;
  logic [15:0]        in_seq;
  logic [7:0]         in_check;
  logic               advance;
  logic               out_valid;
  status_t            filt_status;
  status_t            out_status;
  logic signed [15:0] mix_left;
  logic signed [15:0] mix_right;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;

  // The input stage moves on when the result register is free or taken.
  always_comb begin
    advance   = !out_valid || drv.ready;
    cmd.ready = !in_valid || advance;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_x     <= cmd.stick_x;
      in_y     <= cmd.stick_y;
      in_seq   <= cmd.sequence_number;
      in_check <= cmd.check_byte;
    end
  end

  // Check byte and sequence filtering.
  dcfm_seq_filter u_filter (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_data         (wr_data),
    .step            (in_valid && advance),
    .stick_x         (in_x),
    .stick_y         (in_y),
    .sequence_number (in_seq),
    .check_byte      (in_check),
    .status          (filt_status)
  );

  // Left and right drive mixing.
  dcfm_mixer u_mixer (
    .stick_x     (in_x),
    .stick_y     (in_y),
    .left_drive  (mix_left),
    .right_drive (mix_right)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Drive values are zero for any packet that is not accepted.
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_status <= filt_status;
      out_left   <= (filt_status == ST_OK) ? mix_left : 16'sd0;
      out_right  <= (filt_status == ST_OK) ? mix_right : 16'sd0;
    end
  end

  always_comb begin
    drv.valid       = out_valid;
    drv.status      = out_status;
    drv.left_drive  = out_left;
    drv.right_drive = out_right;
  end

endmodule
